// ----- sv/tsdt_pkg.sv -----
// package: shared types and constants for the tcp session demux table
`timescale 1ns / 1ps

package tsdt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int HANDLE_BITS = 8;
    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    // request kinds
    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_REMOVE   = 2'd1;
    localparam logic [1:0] KIND_LOOKUP   = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // request transfer payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  handle;
        logic [15:0] loc_port;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic        listening;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] match_handle;
        logic       via_listener;
    } out_item_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

// ----- sv/tsdt_ctrl.sv -----
// controller: sequences capture and commit of one request at a time
`timescale 1ns / 1ps

module tsdt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tsdt_pkg::dp_cmd_t cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    // result slot can take a new result this cycle
    assign out_free    = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.capture = (state_reg == ST_IDLE) && s_valid;
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;

    // state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if ((state_reg == ST_EXEC) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/tsdt_datapath.sv -----
// datapath: session table, parallel match, ordered update and result register
`timescale 1ns / 1ps

module tsdt_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsdt_pkg::dp_cmd_t   cmd,
    input  tsdt_pkg::in_item_t  s_data,
    output tsdt_pkg::out_item_t m_data
);

    typedef struct packed {
        logic [tsdt_pkg::HANDLE_BITS-1:0] handle;
        logic [15:0]                      loc_port;
        logic [31:0]                      remote_addr;
        logic [15:0]                      remote_port;
        logic                             listening;
    } entry_t;

    tsdt_pkg::in_item_t  req_reg;
    tsdt_pkg::out_item_t res_reg;
    tsdt_pkg::out_item_t res_next;
    entry_t              table_reg  [tsdt_pkg::TABLE_DEPTH];
    entry_t              table_next [tsdt_pkg::TABLE_DEPTH];
    entry_t              shifted    [tsdt_pkg::TABLE_DEPTH];
    entry_t              new_entry;
    logic [tsdt_pkg::CNT_BITS-1:0] count_reg;
    logic [tsdt_pkg::CNT_BITS-1:0] count_next;
    logic [tsdt_pkg::HANDLE_BITS-1:0] req_handle;

    logic [tsdt_pkg::TABLE_DEPTH-1:0] in_use;
    logic [tsdt_pkg::TABLE_DEPTH-1:0] hit_exact;
    logic [tsdt_pkg::TABLE_DEPTH-1:0] hit_listen;
    logic [tsdt_pkg::TABLE_DEPTH-1:0] hit_handle;
    logic                             exact_any;
    logic                             listen_any;
    logic                             handle_any;
    logic [tsdt_pkg::IDX_BITS-1:0]    exact_idx;
    logic [tsdt_pkg::IDX_BITS-1:0]    listen_idx;
    logic [tsdt_pkg::IDX_BITS-1:0]    rm_idx;
    logic                             full;
    logic                             do_append;
    logic                             do_remove;

    assign req_handle = req_reg.handle[tsdt_pkg::HANDLE_BITS-1:0];
    assign full       = (count_reg == tsdt_pkg::CNT_BITS'(tsdt_pkg::TABLE_DEPTH));
    assign do_append  = cmd.commit && (req_reg.kind == tsdt_pkg::KIND_REGISTER) && !full;
    assign do_remove  = cmd.commit && (req_reg.kind == tsdt_pkg::KIND_REMOVE) && handle_any;

    assign new_entry.handle      = req_handle;
    assign new_entry.loc_port    = req_reg.loc_port;
    assign new_entry.remote_addr = req_reg.remote_addr;
    assign new_entry.remote_port = req_reg.remote_port;
    assign new_entry.listening   = req_reg.listening;

    // per-entry compare against the held request
    always_comb begin
        for (int i = 0; i < tsdt_pkg::TABLE_DEPTH; i++) begin
            in_use[i]     = (tsdt_pkg::CNT_BITS'(i) < count_reg);
            hit_exact[i]  = in_use[i]
                            && (table_reg[i].loc_port == req_reg.loc_port)
                            && (table_reg[i].remote_addr == req_reg.remote_addr)
                            && (table_reg[i].remote_port == req_reg.remote_port);
            hit_listen[i] = in_use[i] && table_reg[i].listening
                            && (table_reg[i].loc_port == req_reg.loc_port);
            hit_handle[i] = in_use[i] && (table_reg[i].handle == req_handle);
        end
    end

    // earliest hit of each kind (scan from the back so the lowest index wins)
    always_comb begin
        exact_any  = 1'b0;
        listen_any = 1'b0;
        handle_any = 1'b0;
        exact_idx  = '0;
        listen_idx = '0;
        rm_idx     = '0;
        for (int i = tsdt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (hit_exact[i]) begin
                exact_any = 1'b1;
                exact_idx = tsdt_pkg::IDX_BITS'(i);
            end
            if (hit_listen[i]) begin
                listen_any = 1'b1;
                listen_idx = tsdt_pkg::IDX_BITS'(i);
            end
            if (hit_handle[i]) begin
                handle_any = 1'b1;
                rm_idx     = tsdt_pkg::IDX_BITS'(i);
            end
        end
    end

    // neighbor feeding each entry when the list closes up
    genvar g;
    generate
        for (g = 0; g < tsdt_pkg::TABLE_DEPTH; g++) begin : g_entry
            if (g < tsdt_pkg::TABLE_DEPTH - 1) begin : g_shift
                assign shifted[g] = table_reg[g + 1];
            end else begin : g_last
                assign shifted[g] = table_reg[g];
            end
        end
    endgenerate

    // next table contents: append at the tail or close up after a removal
    always_comb begin
        for (int i = 0; i < tsdt_pkg::TABLE_DEPTH; i++) begin
            table_next[i] = table_reg[i];
            if (do_append && (tsdt_pkg::CNT_BITS'(i) == count_reg)) begin
                table_next[i] = new_entry;
            end else if (do_remove && (tsdt_pkg::IDX_BITS'(i) >= rm_idx)) begin
                table_next[i] = shifted[i];
            end
        end
    end

    // entry count
    always_comb begin
        count_next = count_reg;
        if (do_append) begin
            count_next = count_reg + 1'b1;
        end else if (do_remove) begin
            count_next = count_reg - 1'b1;
        end
    end

    // result for the held request
    always_comb begin
        res_next.status       = tsdt_pkg::STATUS_NOT_FOUND;
        res_next.match_handle = '0;
        res_next.via_listener = 1'b0;
        case (req_reg.kind)
            tsdt_pkg::KIND_REGISTER: begin
                res_next.status = full ? tsdt_pkg::STATUS_FULL : tsdt_pkg::STATUS_OK;
            end
            tsdt_pkg::KIND_REMOVE: begin
                if (handle_any) begin
                    res_next.status = tsdt_pkg::STATUS_OK;
                end
            end
            tsdt_pkg::KIND_LOOKUP: begin
                if (exact_any) begin
                    res_next.status       = tsdt_pkg::STATUS_OK;
                    res_next.match_handle = 8'(table_reg[exact_idx].handle);
                end else if (listen_any) begin
                    res_next.status       = tsdt_pkg::STATUS_OK;
                    res_next.match_handle = 8'(table_reg[listen_idx].handle);
                    res_next.via_listener = 1'b1;
                end
            end
            default: begin
                res_next.status = tsdt_pkg::STATUS_NOT_FOUND;
            end
        endcase
    end

    // entry count is control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // payload registers: request, table and result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.commit) begin
            res_reg <= res_next;
        end
        for (int i = 0; i < tsdt_pkg::TABLE_DEPTH; i++) begin
            table_reg[i] <= table_next[i];
        end
    end

    assign m_data = res_reg;

endmodule

// ----- sv/tcp_session_demux_table.sv -----
// top level: tcp session demux table with register, remove and lookup
//
// channel   direction  handshake           payload
// s_        in         s_valid / s_ready   tsdt_pkg::in_item_t  (kind, handle, ports, addr)
// m_        out        m_valid / m_ready   tsdt_pkg::out_item_t (status, handle, via_listener)
//
// a request is captured in the idle state; the parallel compare over all table entries,
// the priority select and the table update then commit together in the exec state.
// the result sits in an output register; a new request is taken while it waits.
// a finished request stalls in the exec state until the output register is free.
// aresetn (synchronous, active low) empties the table at once; no clearing pass.
`timescale 1ns / 1ps

module tcp_session_demux_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsdt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tsdt_pkg::out_item_t m_data
);

    tsdt_pkg::dp_cmd_t cmd;

    // sequencing
    tsdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // table and matching
    tsdt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
